// File: rtl/bclp_pkg.sv
// ----------------------------------------------------------------------------
// bclp_pkg
// Shared constants, types and helpers for the command-line parser.
// ----------------------------------------------------------------------------
package bclp_pkg;

	localparam int LINE_CHARS   = 18;
	localparam int BUTTON_COUNT = 15;
	localparam int JOY_WIDTH    = 16;

	localparam int LEN_W     = $clog2(LINE_CHARS + 1);
	localparam int MATCH_LEN = 7;
	localparam int BTN_W     = 4;
	localparam int JOY_WIDE  = JOY_WIDTH + 5;

	typedef logic [7:0]                 byte_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic signed [JOY_WIDTH-1:0] joy_t;
	typedef logic signed [JOY_WIDE-1:0]  joy_wide_t;

	localparam joy_wide_t JOY_MAX_WIDE = {{6{1'b0}}, {(JOY_WIDTH-1){1'b1}}};
	localparam joy_wide_t JOY_MIN_WIDE = {{6{1'b1}}, {(JOY_WIDTH-1){1'b0}}};

	localparam byte_t CH_TAB   = 8'd9;
	localparam byte_t CH_LF    = 8'd10;
	localparam byte_t CH_VT    = 8'd11;
	localparam byte_t CH_FF    = 8'd12;
	localparam byte_t CH_CR    = 8'd13;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_PLUS  = 8'h2B;
	localparam byte_t CH_COMMA = 8'h2C;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_ZERO  = 8'h30;
	localparam byte_t CH_NINE  = 8'h39;
	localparam byte_t CH_LT    = 8'h3C;
	localparam byte_t CH_GT    = 8'h3E;
	localparam byte_t CH_A     = 8'h41;
	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_BTN_LAST = 8'(8'h41 + BUTTON_COUNT - 1);

	// number scanner phase (atoi style)
	typedef enum logic [1:0] {
		PH_SKIP,
		PH_POS,
		PH_NEG,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [BTN_W-1:0] button_code;
		logic             joy_changed;
		joy_t             joy_x;
		joy_t             joy_y;
		logic             connected;
		logic             connect_event;
		logic             lost_event;
	} res_t;

	// "OK+CONN"
	function automatic byte_t conn_char(input logic [2:0] idx);
		byte_t ch;
		case (idx)
			3'd0:    ch = 8'h4F;
			3'd1:    ch = 8'h4B;
			3'd2:    ch = 8'h2B;
			3'd3:    ch = 8'h43;
			3'd4:    ch = 8'h4F;
			3'd5:    ch = 8'h4E;
			3'd6:    ch = 8'h4E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// "OK+LOST"
	function automatic byte_t lost_char(input logic [2:0] idx);
		byte_t ch;
		case (idx)
			3'd0:    ch = 8'h4F;
			3'd1:    ch = 8'h4B;
			3'd2:    ch = 8'h2B;
			3'd3:    ch = 8'h4C;
			3'd4:    ch = 8'h4F;
			3'd5:    ch = 8'h53;
			3'd6:    ch = 8'h54;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/ble_command_line_parser_top.sv
// ----------------------------------------------------------------------------
// ble_command_line_parser_top
// Byte-stream command-line parser: buttons, joystick position, link status.
// ----------------------------------------------------------------------------
// Pipeline: the input register (byte_s1) feeds the line update, and the result
// register (res_s2) holds the item until out_ready takes it.
// Throughput: one item per cycle while out_ready does not stall the result
// register; the line update in bclp_core sets the rate.
// Reset: arst_n clears the line, frame mode, link status and stored position;
// both pipeline stages come up empty.
module ble_command_line_parser_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bclp_pkg::BTN_W-1:0]     button_code,
	output logic                           joy_changed,
	output logic signed [bclp_pkg::JOY_WIDTH-1:0] joy_x,
	output logic signed [bclp_pkg::JOY_WIDTH-1:0] joy_y,
	output logic                           connected,
	output logic                           connect_event,
	output logic                           lost_event
);

	logic            valid_s1;
	bclp_pkg::byte_t byte_s1;
	logic            valid_s2;
	bclp_pkg::res_t  res_s2;
	bclp_pkg::res_t  res;
	logic            advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	bclp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (byte_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
		if (advance)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign button_code   = res_s2.button_code;
	assign joy_changed   = res_s2.joy_changed;
	assign joy_x         = res_s2.joy_x;
	assign joy_y         = res_s2.joy_y;
	assign connected     = res_s2.connected;
	assign connect_event = res_s2.connect_event;
	assign lost_event    = res_s2.lost_event;

endmodule

// File: rtl/bclp_num.sv
// ----------------------------------------------------------------------------
// bclp_num
// One step of an atoi-style scan: whitespace skip, sign, digits, saturation.
// ----------------------------------------------------------------------------
module bclp_num (
	input  bclp_pkg::phase_t phase,
	input  bclp_pkg::joy_t   acc,
	input  bclp_pkg::byte_t  ch,
	output bclp_pkg::phase_t phase_n,
	output bclp_pkg::joy_t   acc_n
);

	logic                 is_dig;
	logic                 is_ws;
	logic [3:0]           dig;
	bclp_pkg::joy_wide_t  acc_w;
	bclp_pkg::joy_wide_t  prod;
	bclp_pkg::joy_wide_t  pos_v;
	bclp_pkg::joy_wide_t  neg_v;
	bclp_pkg::joy_wide_t  dig_w;

	assign is_dig = (ch >= bclp_pkg::CH_ZERO) && (ch <= bclp_pkg::CH_NINE);
	assign is_ws  = (ch == bclp_pkg::CH_SPACE) || (ch == bclp_pkg::CH_TAB) ||
	                (ch == bclp_pkg::CH_VT) || (ch == bclp_pkg::CH_FF);
	assign dig    = 4'(ch - bclp_pkg::CH_ZERO);
	assign dig_w  = bclp_pkg::joy_wide_t'({1'b0, dig});
	assign acc_w  = bclp_pkg::joy_wide_t'(acc);
	// times ten as two shifts
	assign prod   = (acc_w <<< 3) + (acc_w <<< 1);
	assign pos_v  = prod + dig_w;
	assign neg_v  = prod - dig_w;

	always_comb begin
		phase_n = phase;
		acc_n   = acc;
		case (phase)
			bclp_pkg::PH_SKIP: begin
				if (!is_ws) begin
					if (ch == bclp_pkg::CH_PLUS) begin
						phase_n = bclp_pkg::PH_POS;
					end else if (ch == bclp_pkg::CH_MINUS) begin
						phase_n = bclp_pkg::PH_NEG;
					end else if (is_dig) begin
						phase_n = bclp_pkg::PH_POS;
						acc_n   = bclp_pkg::joy_t'(dig_w);
					end else begin
						phase_n = bclp_pkg::PH_DONE;
					end
				end
			end
			bclp_pkg::PH_POS: begin
				if (is_dig) begin
					if (pos_v > bclp_pkg::JOY_MAX_WIDE)
						acc_n = bclp_pkg::joy_t'(bclp_pkg::JOY_MAX_WIDE);
					else
						acc_n = bclp_pkg::joy_t'(pos_v);
				end else begin
					phase_n = bclp_pkg::PH_DONE;
				end
			end
			bclp_pkg::PH_NEG: begin
				if (is_dig) begin
					if (neg_v < bclp_pkg::JOY_MIN_WIDE)
						acc_n = bclp_pkg::joy_t'(bclp_pkg::JOY_MIN_WIDE);
					else
						acc_n = bclp_pkg::joy_t'(neg_v);
				end else begin
					phase_n = bclp_pkg::PH_DONE;
				end
			end
			default: begin
				phase_n = phase;
			end
		endcase
	end

endmodule

// File: rtl/bclp_core.sv
// ----------------------------------------------------------------------------
// bclp_core
// Line state and per-byte update; produces the result of the byte at its input.
// ----------------------------------------------------------------------------
module bclp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  bclp_pkg::byte_t ch,
	output bclp_pkg::res_t  res
);

	bclp_pkg::len_t   len_q,   len_n;
	logic             frame_q, frame_n;
	bclp_pkg::byte_t  first_q, first_n;
	logic             comma_q, comma_n;
	bclp_pkg::joy_t   yacc_q,  yacc_n;
	bclp_pkg::phase_t yph_q,   yph_n;
	bclp_pkg::joy_t   xacc_q,  xacc_n;
	bclp_pkg::phase_t xph_q,   xph_n;
	logic             conn_q,  conn_n;
	logic             lost_q,  lost_n;
	logic             link_q,  link_n;
	bclp_pkg::joy_t   lastx_q, lastx_n;
	bclp_pkg::joy_t   lasty_q, lasty_n;

	bclp_pkg::phase_t yph_f, xph_f;
	bclp_pkg::joy_t   yacc_f, xacc_f;

	logic                       append;
	logic                       clr;
	logic [bclp_pkg::BTN_W-1:0] btn;
	logic                       chg;
	logic                       cev;
	logic                       lev;

	bclp_num u_num_y (
		.phase   (yph_q),
		.acc     (yacc_q),
		.ch      (ch),
		.phase_n (yph_f),
		.acc_n   (yacc_f)
	);

	bclp_num u_num_x (
		.phase   (xph_q),
		.acc     (xacc_q),
		.ch      (ch),
		.phase_n (xph_f),
		.acc_n   (xacc_f)
	);

	assign append = (ch != bclp_pkg::CH_LT) && (ch != bclp_pkg::CH_GT) &&
	                (ch != bclp_pkg::CH_NUL) && (ch != bclp_pkg::CH_LF) &&
	                (ch != bclp_pkg::CH_CR) &&
	                (len_q < bclp_pkg::len_t'(bclp_pkg::LINE_CHARS));

	always_comb begin
		len_n   = len_q;
		frame_n = frame_q;
		first_n = first_q;
		comma_n = comma_q;
		yacc_n  = yacc_q;
		yph_n   = yph_q;
		xacc_n  = xacc_q;
		xph_n   = xph_q;
		conn_n  = conn_q;
		lost_n  = lost_q;
		link_n  = link_q;
		lastx_n = lastx_q;
		lasty_n = lasty_q;
		clr     = 1'b0;
		btn     = '0;
		chg     = 1'b0;
		cev     = 1'b0;
		lev     = 1'b0;

		if (ch == bclp_pkg::CH_LT) begin
			frame_n = 1'b1;
		end else if (ch == bclp_pkg::CH_GT) begin
			clr     = 1'b1;
			frame_n = 1'b0;
			if (len_q != '0 && first_q >= bclp_pkg::CH_A &&
			    first_q <= bclp_pkg::CH_BTN_LAST) begin
				btn = bclp_pkg::BTN_W'(first_q - bclp_pkg::CH_A + 8'd1);
			end else if (comma_q && (xacc_q != lastx_q || yacc_q != lasty_q)) begin
				chg     = 1'b1;
				lastx_n = xacc_q;
				lasty_n = yacc_q;
			end
		end else if (ch != bclp_pkg::CH_NUL) begin
			if (append) begin
				if (len_q == '0)
					first_n = ch;
				if (len_q < bclp_pkg::len_t'(bclp_pkg::MATCH_LEN)) begin
					conn_n = conn_q && (ch == bclp_pkg::conn_char(len_q[2:0]));
					lost_n = lost_q && (ch == bclp_pkg::lost_char(len_q[2:0]));
				end else begin
					conn_n = 1'b0;
					lost_n = 1'b0;
				end
				if (!comma_q) begin
					if (ch == bclp_pkg::CH_COMMA) begin
						comma_n = 1'b1;
					end else begin
						yph_n  = yph_f;
						yacc_n = yacc_f;
					end
				end else begin
					xph_n  = xph_f;
					xacc_n = xacc_f;
				end
				len_n = len_q + 1'b1;
			end
			if (!frame_q) begin
				if (conn_n && len_n == bclp_pkg::len_t'(bclp_pkg::MATCH_LEN)) begin
					clr    = 1'b1;
					link_n = 1'b1;
					cev    = 1'b1;
				end else if (lost_n && len_n == bclp_pkg::len_t'(bclp_pkg::MATCH_LEN)) begin
					clr    = 1'b1;
					link_n = 1'b0;
					lev    = 1'b1;
				end else if (ch == bclp_pkg::CH_LF) begin
					clr = 1'b1;
				end
			end
		end

		if (clr) begin
			len_n   = '0;
			first_n = '0;
			comma_n = 1'b0;
			yacc_n  = '0;
			yph_n   = bclp_pkg::PH_SKIP;
			xacc_n  = '0;
			xph_n   = bclp_pkg::PH_SKIP;
			conn_n  = 1'b1;
			lost_n  = 1'b1;
		end
	end

	always_comb begin
		res.button_code   = btn;
		res.joy_changed   = chg;
		res.joy_x         = lastx_n;
		res.joy_y         = lasty_n;
		res.connected     = link_n;
		res.connect_event = cev;
		res.lost_event    = lev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			frame_q <= 1'b0;
			first_q <= '0;
			comma_q <= 1'b0;
			yacc_q  <= '0;
			yph_q   <= bclp_pkg::PH_SKIP;
			xacc_q  <= '0;
			xph_q   <= bclp_pkg::PH_SKIP;
			conn_q  <= 1'b1;
			lost_q  <= 1'b1;
			link_q  <= 1'b0;
			lastx_q <= '0;
			lasty_q <= '0;
		end else if (step) begin
			len_q   <= len_n;
			frame_q <= frame_n;
			first_q <= first_n;
			comma_q <= comma_n;
			yacc_q  <= yacc_n;
			yph_q   <= yph_n;
			xacc_q  <= xacc_n;
			xph_q   <= xph_n;
			conn_q  <= conn_n;
			lost_q  <= lost_n;
			link_q  <= link_n;
			lastx_q <= lastx_n;
			lasty_q <= lasty_n;
		end
	end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the command-line parser and checks each status
// item against a cycle-free line parser that runs alongside the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bclp_pkg::*;

	localparam int    IDLE_PCT   = 26;
	localparam int    QUIET_FROM = 1500;
	localparam int    QUIET_TO   = 2600;
	localparam int    NUM_BYTES  = 1750;
	localparam string CONN_TEXT  = "OK+CONN";
	localparam string LOST_TEXT  = "OK+LOST";
	localparam int    POS_MAX    = (1 << (JOY_WIDTH - 1)) - 1;
	localparam int    POS_MIN    = -POS_MAX - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [BTN_W-1:0] button_code;
	logic joy_changed;
	logic signed [JOY_WIDTH-1:0] joy_x;
	logic signed [JOY_WIDTH-1:0] joy_y;
	logic connected;
	logic connect_event;
	logic lost_event;

	ble_command_line_parser_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.button_code(button_code),
		.joy_changed(joy_changed),
		.joy_x(joy_x),
		.joy_y(joy_y),
		.connected(connected),
		.connect_event(connect_event),
		.lost_event(lost_event)
	);

	always #10 clk = ~clk;

	byte_t pending_bytes[$];
	res_t  predicted_status[$];
	int    drain_marks[$];
	int    stim_bytes = 0;
	int    n_sent = 0;
	int    errors = 0;
	int    cycle_cnt = 0;
	wire   no_idle = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

	// parser state
	int     line_len;
	bit     frame_mode;
	byte_t  line_first;
	bit     line_comma;
	int     y_val, x_val;
	phase_t y_ph, x_ph;
	bit     conn_match, lost_match;
	bit     link_up;
	int     pos_x, pos_y;

	function automatic void clear_line_state();
		line_len   = 0;
		line_first = 8'd0;
		line_comma = 1'b0;
		y_val      = 0;
		x_val      = 0;
		y_ph       = PH_SKIP;
		x_ph       = PH_SKIP;
		conn_match = 1'b1;
		lost_match = 1'b1;
	endfunction

	function automatic void scan_number(inout phase_t ph, inout int acc, input byte_t c);
		bit is_dig;
		int d;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = int'(c) - int'(CH_ZERO);
		case (ph)
			PH_SKIP: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
					;
				else if (c == CH_PLUS)
					ph = PH_POS;
				else if (c == CH_MINUS)
					ph = PH_NEG;
				else if (is_dig) begin
					ph = PH_POS;
					acc = d;
				end else
					ph = PH_DONE;
			end
			PH_POS: begin
				if (is_dig) begin
					acc = acc * 10 + d;
					if (acc > POS_MAX) acc = POS_MAX;
				end else
					ph = PH_DONE;
			end
			PH_NEG: begin
				if (is_dig) begin
					acc = acc * 10 - d;
					if (acc < POS_MIN) acc = POS_MIN;
				end else
					ph = PH_DONE;
			end
			default: ;
		endcase
	endfunction

	function automatic void append_to_line(input byte_t c);
		if (line_len == 0) line_first = c;
		if (line_len < CONN_TEXT.len()) begin
			if (c != byte_t'(CONN_TEXT[line_len])) conn_match = 1'b0;
			if (c != byte_t'(LOST_TEXT[line_len])) lost_match = 1'b0;
		end else begin
			conn_match = 1'b0;
			lost_match = 1'b0;
		end
		if (!line_comma) begin
			if (c == CH_COMMA) line_comma = 1'b1;
			else scan_number(y_ph, y_val, c);
		end else
			scan_number(x_ph, x_val, c);
		line_len++;
	endfunction

	function automatic void parse_rx_byte(input byte_t c);
		res_t  r;
		bit    have, comma;
		byte_t f;
		int    nx, ny;
		r = '0;
		if (c == CH_LT)
			frame_mode = 1'b1;
		else if (c == CH_GT) begin
			have  = line_len > 0;
			f     = line_first;
			comma = line_comma;
			ny    = y_val;
			nx    = x_val;
			clear_line_state();
			frame_mode = 1'b0;
			if (have && f >= CH_A && f <= CH_BTN_LAST)
				r.button_code = BTN_W'(f - CH_A + 1);
			else if (comma && (nx != pos_x || ny != pos_y)) begin
				r.joy_changed = 1'b1;
				pos_x = nx;
				pos_y = ny;
			end
		end else if (c != CH_NUL) begin
			if (c != CH_LF && c != CH_CR && line_len < LINE_CHARS) append_to_line(c);
			if (!frame_mode) begin
				if (conn_match && line_len == MATCH_LEN) begin
					clear_line_state();
					link_up = 1'b1;
					r.connect_event = 1'b1;
				end else if (lost_match && line_len == MATCH_LEN) begin
					clear_line_state();
					link_up = 1'b0;
					r.lost_event = 1'b1;
				end else if (c == CH_LF)
					clear_line_state();
			end
		end
		r.joy_x = joy_t'(pos_x);
		r.joy_y = joy_t'(pos_y);
		r.connected = link_up;
		predicted_status.push_back(r);
	endfunction

	// ---------------- stimulus ----------------
	function automatic void add_byte(input byte_t c);
		pending_bytes.push_back(c);
		if (c != CH_NUL) stim_bytes++;
	endfunction

	function automatic void add_text(input string s);
		foreach (s[i]) add_byte(byte_t'(s[i]));
	endfunction

	function automatic void add_number();
		int n_ws, n_dig, k;
		n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n_ws) begin
			k = $urandom_range(0, 4);
			add_byte(k == 0 ? CH_SPACE : k == 1 ? CH_TAB : k == 2 ? CH_VT :
				k == 3 ? CH_FF : CH_CR);
		end
		k = $urandom_range(0, 5);
		if (k == 0) add_byte(CH_PLUS);
		else if (k < 3) add_byte(CH_MINUS);
		n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
		repeat (n_dig) add_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	// mostly well-formed frames and link messages, the rest noise and fragments
	function automatic void add_sequence();
		int    kind, bad, n;
		string msg;
		kind = $urandom_range(0, 99);
		if (kind < 48) begin
			n = $urandom_range(0, 2);
			if (n == 0) add_byte(CH_GT);
			else if (n == 1) add_byte(CH_LF);
			add_byte(CH_LT);
			if (kind < 30) begin
				add_number();
				add_byte(CH_COMMA);
				add_number();
				if ($urandom_range(0, 5) == 0) begin
					add_byte($urandom_range(0, 1) ? CH_COMMA : byte_t'($urandom_range(32, 126)));
					add_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
				end
			end else begin
				add_byte(byte_t'($urandom_range(8'h40, 8'h5A)));
				repeat ($urandom_range(0, 3)) add_byte(byte_t'($urandom_range(32, 126)));
			end
			add_byte(CH_GT);
		end else if (kind < 62) begin
			if ($urandom_range(0, 1)) add_byte(CH_LF);
			if ($urandom_range(0, 7) == 0) add_byte(CH_LT);
			msg = $urandom_range(0, 1) ? CONN_TEXT : LOST_TEXT;
			bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : -1;
			foreach (msg[i]) begin
				if ($urandom_range(0, 15) == 0) add_byte(CH_CR);
				if (i == bad) add_byte(byte_t'($urandom_range(32, 126)));
				else add_byte(byte_t'(msg[i]));
			end
			if ($urandom_range(0, 2) == 0) add_byte(CH_LF);
		end else if (kind < 70) begin
			if ($urandom_range(0, 1)) add_byte(CH_LT);
			add_byte(CH_GT);
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 24)) add_byte(byte_t'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(0, 3);
			if (n == 0) begin
				// long line past the length limit
				add_byte(CH_LT);
				repeat ($urandom_range(17, 24)) add_byte(byte_t'(CH_ZERO + $urandom_range(0, 9)));
				add_byte(CH_COMMA);
				add_number();
				add_byte(CH_GT);
			end else if (n == 1) begin
				add_byte(CH_LT);
				add_number();
				add_byte($urandom_range(0, 1) ? CH_LT : CH_LF);
			end else begin
				msg = $urandom_range(0, 1) ? CONN_TEXT : LOST_TEXT;
				add_byte(CH_LF);
				bad = $urandom_range(1, 6);
				for (int i = 0; i < bad; i++) add_byte(byte_t'(msg[i]));
				add_byte(n == 2 ? CH_LF : CH_NUL);
			end
		end
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	always @(posedge clk) begin
		bit hold;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'd0;
		end else begin
			if (in_valid && in_ready) begin
				parse_rx_byte(rx_byte);
				n_sent++;
			end
			hold = (drain_marks.size() > 0) && (n_sent == drain_marks[0]);
			if (hold && predicted_status.size() == 0) begin
				void'(drain_marks.pop_front());
				hold = 1'b0;
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() > 0 && !hold &&
					(no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					rx_byte  <= pending_bytes.pop_front();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	function automatic void check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		res_t exp_r;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (predicted_status.size() == 0) begin
					$display("%0t: unexpected item, actual button %0d x %0d y %0d",
						$time, button_code, joy_x, joy_y);
					errors++;
				end else begin
					exp_r = predicted_status.pop_front();
					check_field("button_code", exp_r.button_code, button_code);
					check_field("joy_changed", exp_r.joy_changed, joy_changed);
					check_field("joy_x", exp_r.joy_x, joy_x);
					check_field("joy_y", exp_r.joy_y, joy_y);
					check_field("connected", exp_r.connected, connected);
					check_field("connect_event", exp_r.connect_event, connect_event);
					check_field("lost_event", exp_r.lost_event, lost_event);
				end
			end
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ---------------- sequencing ----------------
	initial begin
		clear_line_state();
		frame_mode = 1'b0;
		link_up    = 1'b0;
		pos_x      = 0;
		pos_y      = 0;

		add_byte(CH_NUL);
		add_text(CONN_TEXT);
		add_text("<>");
		add_text("<O>");
		add_byte(8'hFF);
		add_byte(CH_LF);
		add_text("<-99999,+7,1>");
		drain_marks.push_back(pending_bytes.size());
		while (stim_bytes < NUM_BYTES) begin
			add_sequence();
			if (drain_marks.size() == 1 && stim_bytes >= NUM_BYTES / 2)
				drain_marks.push_back(pending_bytes.size());
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
		while (predicted_status.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
